/* hw/rtl/gtf_pkg.sv */
// ============================================================================
// gtf_pkg
// Shared types, register codes and the microcode program of the gimbal
// target follower.
// ============================================================================
package gtf_pkg;

    // Fixed field widths
    localparam int POS_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int PULSE_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_MIN      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_MAX      = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_DEADBAND      = 16'd3277;
    localparam logic [GAIN_W-1:0]  RST_SMOOTH_GAIN   = 16'd6554;
    localparam logic [GAIN_W-1:0]  RST_APPROACH_GAIN = 16'd3932;
    localparam logic [GAIN_W-1:0]  RST_RETURN_GAIN   = 16'd3277;
    localparam logic [PULSE_W-1:0] RST_PAN_MIN       = 12'd500;
    localparam logic [PULSE_W-1:0] RST_PAN_MAX       = 12'd2500;
    localparam logic [PULSE_W-1:0] RST_TILT_MIN      = 12'd1000;
    localparam logic [PULSE_W-1:0] RST_TILT_MAX      = 12'd2000;

    // Smoothed position after reset or target loss: one half
    localparam logic [POS_W-1:0] POS_HALF = 16'd32768;

    // Payloads
    typedef struct packed {
        logic [POS_W-1:0] track_x;
        logic [POS_W-1:0] track_y;
        logic             detected;
    } t_in;

    typedef struct packed {
        logic [PULSE_W-1:0] pan_pulse;
        logic [PULSE_W-1:0] tilt_pulse;
    } t_out;

    // Configuration register file contents
    typedef struct packed {
        logic [GAIN_W-1:0]  deadband;
        logic [GAIN_W-1:0]  smooth_gain;
        logic [GAIN_W-1:0]  approach_gain;
        logic [GAIN_W-1:0]  return_gain;
        logic [PULSE_W-1:0] pan_min;
        logic [PULSE_W-1:0] pan_max;
        logic [PULSE_W-1:0] tilt_min;
        logic [PULSE_W-1:0] tilt_max;
    } t_cfg;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIFF,    // e = t - s, deadband test
        OP_MULD,    // prod = smooth_gain * e
        OP_UPDS,    // s += prod >> 16 when outside deadband
        OP_MULS,    // prod = s * (max - min)
        OP_TGT,     // e = target level - level
        OP_CTR,     // e = center level - level
        OP_MULLO,   // lo = (gain * e[15:0]) >> 16
        OP_MULHI,   // prod = gain * (e >>> 16)
        OP_ADDL,    // level = clamp(level + lo + prod)
        OP_RSTS,    // both smoothed positions back to one half
        OP_OUT      // load the output register
    } t_uop;

    typedef enum logic {
        GS_APPROACH,
        GS_RETURN
    } t_gsel;

    typedef enum logic {
        JC_NONE,
        JC_NDET     // jump when the target is not detected
    } t_jcond;

    // One control word
    typedef struct packed {
        t_uop             op;
        logic             axis;     // 0 pan, 1 tilt
        t_gsel            gsel;
        t_jcond           jc;
        logic [PC_W-1:0]  target;
        logic             last;
    } t_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic det;
        logic out_ok;
    } t_stat;

    // Program entry for the lost-target path
    localparam logic [PC_W-1:0] PC_LOST = 5'd18;

    function automatic t_ctrl uw(input t_uop op, input logic axis, input t_gsel gsel,
                                 input t_jcond jc, input logic [PC_W-1:0] target,
                                 input logic last);
        t_ctrl w;
        w.op     = op;
        w.axis   = axis;
        w.gsel   = gsel;
        w.jc     = jc;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    localparam t_ctrl CTRL_IDLE = '{op: OP_NOP, axis: 1'b0, gsel: GS_APPROACH,
                                    jc: JC_NONE, target: '0, last: 1'b0};

    // Microcode ROM
    function automatic t_ctrl gtf_ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            // dispatch on the detected flag
            5'd0:  w = uw(OP_NOP,   1'b0, GS_APPROACH, JC_NDET, PC_LOST, 1'b0);
            // tracking, pan
            5'd1:  w = uw(OP_DIFF,  1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd2:  w = uw(OP_MULD,  1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd3:  w = uw(OP_UPDS,  1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd4:  w = uw(OP_MULS,  1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd5:  w = uw(OP_TGT,   1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd6:  w = uw(OP_MULLO, 1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd7:  w = uw(OP_MULHI, 1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd8:  w = uw(OP_ADDL,  1'b0, GS_APPROACH, JC_NONE, '0, 1'b0);
            // tracking, tilt
            5'd9:  w = uw(OP_DIFF,  1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd10: w = uw(OP_MULD,  1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd11: w = uw(OP_UPDS,  1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd12: w = uw(OP_MULS,  1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd13: w = uw(OP_TGT,   1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd14: w = uw(OP_MULLO, 1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd15: w = uw(OP_MULHI, 1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd16: w = uw(OP_ADDL,  1'b1, GS_APPROACH, JC_NONE, '0, 1'b0);
            5'd17: w = uw(OP_OUT,   1'b0, GS_APPROACH, JC_NONE, '0, 1'b1);
            // target lost: return both levels to center, then reset both smoothed positions
            5'd18: w = uw(OP_CTR,   1'b0, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd19: w = uw(OP_MULLO, 1'b0, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd20: w = uw(OP_MULHI, 1'b0, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd21: w = uw(OP_ADDL,  1'b0, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd22: w = uw(OP_CTR,   1'b1, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd23: w = uw(OP_MULLO, 1'b1, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd24: w = uw(OP_MULHI, 1'b1, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd25: w = uw(OP_ADDL,  1'b1, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd26: w = uw(OP_RSTS,  1'b0, GS_RETURN,   JC_NONE, '0, 1'b0);
            5'd27: w = uw(OP_OUT,   1'b0, GS_RETURN,   JC_NONE, '0, 1'b1);
            // unused addresses end the program
            default: w = uw(OP_NOP, 1'b0, GS_APPROACH, JC_NONE, '0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/gtf_cfg_regs.sv */
// ============================================================================
// gtf_cfg_regs
// Configuration register file: gains, deadband and servo pulse ranges.
// ============================================================================
module gtf_cfg_regs
    import gtf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband      <= RST_DEADBAND;
            r_cfg.smooth_gain   <= RST_SMOOTH_GAIN;
            r_cfg.approach_gain <= RST_APPROACH_GAIN;
            r_cfg.return_gain   <= RST_RETURN_GAIN;
            r_cfg.pan_min       <= RST_PAN_MIN;
            r_cfg.pan_max       <= RST_PAN_MAX;
            r_cfg.tilt_min      <= RST_TILT_MIN;
            r_cfg.tilt_max      <= RST_TILT_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEADBAND:      r_cfg.deadband      <= i_cfg_data;
                CFG_SMOOTH_GAIN:   r_cfg.smooth_gain   <= i_cfg_data;
                CFG_APPROACH_GAIN: r_cfg.approach_gain <= i_cfg_data;
                CFG_RETURN_GAIN:   r_cfg.return_gain   <= i_cfg_data;
                CFG_PAN_MIN:       r_cfg.pan_min       <= i_cfg_data[PULSE_W-1:0];
                CFG_PAN_MAX:       r_cfg.pan_max       <= i_cfg_data[PULSE_W-1:0];
                CFG_TILT_MIN:      r_cfg.tilt_min      <= i_cfg_data[PULSE_W-1:0];
                CFG_TILT_MAX:      r_cfg.tilt_max      <= i_cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/gtf_sequencer.sv */
// ============================================================================
// gtf_sequencer
// Step counter and microcode ROM: accepts an item, walks the program and
// issues one control word per cycle to the datapath, except while held at a stalled output step.
// ============================================================================
module gtf_sequencer
    import gtf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_in_accept,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic            r_busy;
    logic            n_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           rom_word;

    assign o_in_stall  = r_busy;
    assign o_in_accept = i_in_valid && !r_busy;
    assign rom_word    = gtf_ucode(r_pc);
    assign o_ctrl      = r_busy ? rom_word : CTRL_IDLE;

    // Step counter and jump logic
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        priority if (!r_busy) begin
            if (i_in_valid) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else if (rom_word.op == OP_OUT && !i_stat.out_ok) begin
            // output register still full: hold this step
            n_pc = r_pc;
        end else if (rom_word.last) begin
            n_busy = 1'b0;
        end else if (rom_word.jc == JC_NDET && !i_stat.det) begin
            n_pc = rom_word.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

/* hw/rtl/gtf_datapath.sv */
// ============================================================================
// gtf_datapath
// Axis state, one shared signed multiplier, adders and the output register,
// all steered by the sequencer's control word.
// ============================================================================
module gtf_datapath
    import gtf_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CENTER_PULSE = 1500
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_cfg  i_cfg,
    input  logic  i_in_accept,
    input  t_in   i_in_data,
    output t_stat o_stat,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_out  o_out_data
);

    localparam int LW   = PULSE_W + FRAC_BITS;          // level width
    localparam int EW   = LW + 2;                       // error word
    localparam int HW   = EW - POS_W;                   // error high part
    localparam int MBW  = (HW > POS_W + 1) ? HW : POS_W + 1;
    localparam int AW   = GAIN_W + 1;
    localparam int PW   = AW + MBW;                     // product width
    localparam int SW   = LW + 2;                       // level sum width
    localparam int SH_L = (FRAC_BITS >= POS_W) ? FRAC_BITS - POS_W : 0;
    localparam int SH_R = (FRAC_BITS <  POS_W) ? POS_W - FRAC_BITS : 0;
    localparam int XW   = PW + SH_L;

    localparam logic [LW-1:0] CTR_L = LW'(CENTER_PULSE) << FRAC_BITS;
    localparam logic [EW-1:0] CTR_E = EW'(CENTER_PULSE) << FRAC_BITS;

    // State and working registers
    t_in                   r_item;
    logic [POS_W-1:0]      r_sx;
    logic [POS_W-1:0]      r_sy;
    logic [LW-1:0]         r_pl;
    logic [LW-1:0]         r_tl;
    logic signed [EW-1:0]  r_e;
    logic                  r_upd;
    logic [POS_W-1:0]      r_lo;
    logic signed [PW-1:0]  r_prod;
    logic                  r_out_valid;
    t_out                  r_out_data;

    // Axis selection
    logic [POS_W-1:0]      cur_t;
    logic [POS_W-1:0]      cur_s;
    logic [LW-1:0]         cur_l;
    logic [PULSE_W-1:0]    cur_mn;
    logic [PULSE_W-1:0]    cur_mx;
    logic [GAIN_W-1:0]     gain;

    logic signed [POS_W:0]   d;
    logic [POS_W:0]          d_mag;
    logic signed [PULSE_W:0] span;

    logic signed [AW-1:0]  mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;

    logic signed [XW-1:0]  sc_x;
    logic signed [XW-1:0]  sc_s;
    logic signed [EW-1:0]  mx_f;
    logic signed [EW-1:0]  l_e;
    logic signed [EW-1:0]  e_tgt;
    logic signed [EW-1:0]  e_ctr;
    logic signed [POS_W+1:0] s_sum;
    logic [POS_W-1:0]      s_new;
    logic signed [SW-1:0]  l_sum;
    logic [LW-1:0]         l_new;
    logic                  out_ok;
    logic                  out_load;

    assign cur_t  = i_ctrl.axis ? r_item.track_y : r_item.track_x;
    assign cur_s  = i_ctrl.axis ? r_sy : r_sx;
    assign cur_l  = i_ctrl.axis ? r_tl : r_pl;
    assign cur_mn = i_ctrl.axis ? i_cfg.tilt_min : i_cfg.pan_min;
    assign cur_mx = i_ctrl.axis ? i_cfg.tilt_max : i_cfg.pan_max;
    assign gain   = (i_ctrl.gsel == GS_RETURN) ? i_cfg.return_gain : i_cfg.approach_gain;

    // Position error and range span
    assign d     = $signed({1'b0, cur_t}) - $signed({1'b0, cur_s});
    assign d_mag = d[POS_W] ? (POS_W + 1)'(-d) : d;
    assign span  = $signed({1'b0, cur_mx}) - $signed({1'b0, cur_mn});

    // Shared multiplier operand select
    always_comb begin
        unique case (i_ctrl.op)
            OP_MULD: begin
                mul_a = $signed({1'b0, i_cfg.smooth_gain});
                mul_b = MBW'($signed(r_e[POS_W:0]));
            end
            OP_MULS: begin
                mul_a = $signed({1'b0, cur_s});
                mul_b = MBW'(span);
            end
            OP_MULLO: begin
                mul_a = $signed({1'b0, gain});
                mul_b = $signed(MBW'(r_e[POS_W-1:0]));
            end
            OP_MULHI: begin
                mul_a = $signed({1'b0, gain});
                mul_b = MBW'($signed(r_e[EW-1:POS_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Target level: max << F minus the rescaled span product
    assign sc_x  = XW'(r_prod);
    assign sc_s  = (FRAC_BITS >= POS_W) ? (sc_x <<< SH_L) : (sc_x >>> SH_R);
    assign mx_f  = $signed(EW'({cur_mx, {FRAC_BITS{1'b0}}}));
    assign l_e   = $signed(EW'(cur_l));
    assign e_tgt = mx_f - EW'(sc_s) - l_e;
    assign e_ctr = $signed(CTR_E) - l_e;

    // Smoothed position update
    assign s_sum = $signed({2'b00, cur_s}) + $signed((POS_W + 2)'(r_prod >>> POS_W));
    assign s_new = s_sum[POS_W-1:0];

    // Level update with clamp to the level range
    assign l_sum = $signed(SW'(cur_l)) + $signed(SW'(r_lo)) + SW'(r_prod);
    always_comb begin
        priority if (l_sum[SW-1]) begin
            l_new = '0;
        end else if (|l_sum[SW-2:LW]) begin
            l_new = '1;
        end else begin
            l_new = l_sum[LW-1:0];
        end
    end

    // Output register handshake
    assign out_ok   = !r_out_valid || !i_out_stall;
    assign out_load = (i_ctrl.op == OP_OUT) && out_ok;

    assign o_stat.det    = r_item.detected;
    assign o_stat.out_ok = out_ok;
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out_data;

    // Axis state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx        <= POS_HALF;
            r_sy        <= POS_HALF;
            r_pl        <= CTR_L;
            r_tl        <= CTR_L;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.op == OP_UPDS && r_upd) begin
                if (i_ctrl.axis) begin
                    r_sy <= s_new;
                end else begin
                    r_sx <= s_new;
                end
            end
            if (i_ctrl.op == OP_RSTS) begin
                r_sx <= POS_HALF;
                r_sy <= POS_HALF;
            end
            if (i_ctrl.op == OP_ADDL) begin
                if (i_ctrl.axis) begin
                    r_tl <= l_new;
                end else begin
                    r_pl <= l_new;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and payloads
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out_data.pan_pulse  <= r_pl[LW-1:FRAC_BITS];
            r_out_data.tilt_pulse <= r_tl[LW-1:FRAC_BITS];
        end
        unique case (i_ctrl.op)
            OP_DIFF: begin
                r_e   <= EW'(d);
                r_upd <= d_mag > {1'b0, i_cfg.deadband};
            end
            OP_TGT:   r_e    <= e_tgt;
            OP_CTR:   r_e    <= e_ctr;
            OP_MULD,
            OP_MULS,
            OP_MULHI: r_prod <= mul_p;
            OP_MULLO: r_lo   <= mul_p[2*POS_W-1:POS_W];
            default: ;
        endcase
    end

endmodule

/* hw/rtl/gimbal_target_follower_core.sv */
// ============================================================================
// gimbal_target_follower_core
// Two-axis pan/tilt follower with deadband, exponential position smoothing
// and gain-stepped servo pulse levels.
// ============================================================================
// One item is taken at a time, and the next item is accepted in the cycle
// after the result is loaded into the output register. A lost-target item
// runs a shorter program path than a detected item. The run time of an item
// is the length of the microcode program, which runs every multiply of both
// axes through one shared 17-bit by 17-bit-or-wider multiplier, one step per
// cycle. The output register holds a result while the sink stalls and the
// sequencer then waits at its output step.
module gimbal_target_follower_core
    import gtf_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CENTER_PULSE = 1500
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_ctrl ctrl;
    t_stat stat;
    logic  in_accept;

    gtf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gtf_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_in_accept (in_accept),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    gtf_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .CENTER_PULSE (CENTER_PULSE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cfg       (cfg),
        .i_in_accept (in_accept),
        .i_in_data   (i_in_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/gtf_checker.sv */
// ============================================================================
// gtf_checker
// Port-level checks of the follower core over time, bound to the top level.
// ============================================================================
module gtf_checker
    import gtf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // An accepted item raises the input stall
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // No result appears unless an item was in flight
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |=> !$rose(o_out_valid))
        else $error("result without an item in flight");

    // The input reopens only together with a loaded result
    a_done_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("item finished without a result");

endmodule

bind gimbal_target_follower_core gtf_checker u_gtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* sim/gimbal_target_follower_core_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// gimbal_target_follower_core_test
// Self-checking bench for the pan/tilt follower core. A driver and a monitor
// run as clocked processes around the core; every accepted frame is pushed
// through a local fixed-point predictor of the smoothing, deadband and
// gain-stepped level update, and every accepted pulse pair is compared with
// the oldest prediction. Phases switch the register settings between runs of
// directed, tracking, lost-target and noise frames.
// ============================================================================
module gimbal_target_follower_core_test;
    import gtf_pkg::*;

    localparam int FRAC      = 16;
    localparam int CENTER    = 1500;
    localparam int LIMIT     = 400000;
    localparam int N_PHASES  = 9;
    localparam int PHASE_LEN = 160;
    localparam int HOLD_LEN  = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_DEADBAND;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    gimbal_target_follower_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Frames waiting to be sent and pulse pairs waiting to come back
    t_in  frame_q[$];
    t_out pulse_due[$];

    int   n_queued = 0;
    int   n_done = 0;
    int   errors = 0;
    int   cycles = 0;
    int   in_wait = 0;
    int   out_wait = 0;
    int   hold_left = 0;
    bit   in_idle_on = 1'b1;
    bit   out_idle_on = 1'b1;
    t_out want;

    // Predictor state and register copy
    t_cfg   cfg_now;
    longint pos_x, pos_y;
    longint lvl_pan, lvl_tilt;

    // ------------------------------------------------------------------------
    // Fixed-point follower predictor
    // ------------------------------------------------------------------------

    // cur + floor(gain * (goal - cur) / 2^16)
    function automatic longint ease(input longint cur, input longint goal,
                                    input logic [GAIN_W-1:0] g);
        return cur + ((longint'(g) * (goal - cur)) >>> 16);
    endfunction

    function automatic longint pin_level(input longint v);
        longint top;
        top = (longint'(4096) <<< FRAC) - 1;
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    // Smoothed position only moves when the target leaves the deadband
    function automatic longint chase_pos(input longint s, input logic [POS_W-1:0] t);
        longint d;
        longint mag;
        d   = longint'(t) - s;
        mag = (d < 0) ? -d : d;
        if (mag > longint'(cfg_now.deadband))
            s = ease(s, longint'(t), cfg_now.smooth_gain);
        return s;
    endfunction

    // Inverse map of position onto the pulse range, works for swapped ranges
    function automatic longint aim_level(input longint s, input logic [PULSE_W-1:0] lo,
                                         input logic [PULSE_W-1:0] hi);
        return (longint'(hi) <<< FRAC) - s * (longint'(hi) - longint'(lo));
    endfunction

    function automatic t_out follow_step(input t_in f);
        t_out   r;
        longint ctr;
        ctr = longint'(CENTER) <<< FRAC;
        if (f.detected) begin
            pos_x    = chase_pos(pos_x, f.track_x);
            pos_y    = chase_pos(pos_y, f.track_y);
            lvl_pan  = pin_level(ease(lvl_pan,
                           aim_level(pos_x, cfg_now.pan_min, cfg_now.pan_max),
                           cfg_now.approach_gain));
            lvl_tilt = pin_level(ease(lvl_tilt,
                           aim_level(pos_y, cfg_now.tilt_min, cfg_now.tilt_max),
                           cfg_now.approach_gain));
        end else begin
            lvl_pan  = pin_level(ease(lvl_pan, ctr, cfg_now.return_gain));
            lvl_tilt = pin_level(ease(lvl_tilt, ctr, cfg_now.return_gain));
            pos_x    = longint'(POS_HALF);
            pos_y    = longint'(POS_HALF);
        end
        r.pan_pulse  = PULSE_W'(lvl_pan >>> FRAC);
        r.tilt_pulse = PULSE_W'(lvl_tilt >>> FRAC);
        return r;
    endfunction

    task automatic report(input string what, input int unsigned exp_v,
                          input int unsigned got_v);
        $display("ERROR %s at result %0d: expected %0d, got %0d",
                 what, n_done, exp_v, got_v);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Register writes and frame generation
    // ------------------------------------------------------------------------

    // One register transaction; the predictor copy follows on acceptance
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEADBAND:      cfg_now.deadband      = v;
            CFG_SMOOTH_GAIN:   cfg_now.smooth_gain   = v;
            CFG_APPROACH_GAIN: cfg_now.approach_gain = v;
            CFG_RETURN_GAIN:   cfg_now.return_gain   = v;
            CFG_PAN_MIN:       cfg_now.pan_min       = v[PULSE_W-1:0];
            CFG_PAN_MAX:       cfg_now.pan_max       = v[PULSE_W-1:0];
            CFG_TILT_MIN:      cfg_now.tilt_min      = v[PULSE_W-1:0];
            CFG_TILT_MAX:      cfg_now.tilt_max      = v[PULSE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pulse registers get random junk above bit 11, which must be dropped
    task automatic set_all(input logic [15:0] db, input logic [15:0] sg,
                           input logic [15:0] ag, input logic [15:0] rg,
                           input logic [11:0] pmin, input logic [11:0] pmax,
                           input logic [11:0] tmin, input logic [11:0] tmax);
        put_reg(CFG_DEADBAND, db);
        put_reg(CFG_SMOOTH_GAIN, sg);
        put_reg(CFG_APPROACH_GAIN, ag);
        put_reg(CFG_RETURN_GAIN, rg);
        put_reg(CFG_PAN_MIN, {4'($urandom), pmin});
        put_reg(CFG_PAN_MAX, {4'($urandom), pmax});
        put_reg(CFG_TILT_MIN, {4'($urandom), tmin});
        put_reg(CFG_TILT_MAX, {4'($urandom), tmax});
    endtask

    task automatic push_frame(input logic [15:0] x, input logic [15:0] y, input bit det);
        t_in f;
        f.track_x  = x;
        f.track_y  = y;
        f.detected = det;
        frame_q.push_back(f);
        n_queued++;
    endtask

    // Mostly tracking runs of a drifting target, some lost runs and noise
    task automatic queue_frames(input int count);
        int          kind;
        int          run;
        int          step;
        logic [15:0] bx, by;
        while (count > 0) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                push_frame(16'($urandom), 16'($urandom), 1'($urandom));
                count--;
            end else if (kind <= 2) begin
                run = $urandom_range(1, 4);
                repeat (run) begin
                    push_frame(16'($urandom), 16'($urandom), 1'b0);
                    count--;
                end
            end else begin
                run  = $urandom_range(3, 25);
                step = 1 << $urandom_range(4, 13);
                bx   = 16'($urandom);
                by   = 16'($urandom);
                repeat (run) begin
                    bx = bx + 16'($urandom_range(0, 2 * step) - step);
                    by = by + 16'($urandom_range(0, 2 * step) - step);
                    push_frame(bx, by, $urandom_range(0, 19) != 0);
                    count--;
                end
            end
        end
    endtask

    task automatic wait_drained;
        while (n_done < n_queued)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Frame driver: holds a stalled transaction, idles a drawn gap after each
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pulse_due.push_back(follow_step(i_in_data));
                in_wait = in_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (in_wait > 0) begin
                    in_wait--;
                    i_in_valid <= 1'b0;
                end else if (frame_q.size() > 0) begin
                    i_in_data  <= frame_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pulse monitor: checks each transaction, stalls at random, and twice
    // holds off long enough for the core to back up into its input
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_done++;
                if (pulse_due.size() == 0) begin
                    report("unexpected result", 0, 32'(o_out_data));
                end else begin
                    want = pulse_due.pop_front();
                    if (o_out_data.pan_pulse != want.pan_pulse)
                        report("pan_pulse", 32'(want.pan_pulse),
                               32'(o_out_data.pan_pulse));
                    if (o_out_data.tilt_pulse != want.tilt_pulse)
                        report("tilt_pulse", 32'(want.tilt_pulse),
                               32'(o_out_data.tilt_pulse));
                end
                out_wait = out_idle_on ? $urandom_range(0, 4) : 0;
                if (n_done == 60 || n_done == 900)
                    hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed frames on reset settings, then random phases
    // ------------------------------------------------------------------------
    initial begin
        cfg_now = '{deadband: RST_DEADBAND, smooth_gain: RST_SMOOTH_GAIN,
                    approach_gain: RST_APPROACH_GAIN, return_gain: RST_RETURN_GAIN,
                    pan_min: RST_PAN_MIN, pan_max: RST_PAN_MAX,
                    tilt_min: RST_TILT_MIN, tilt_max: RST_TILT_MAX};
        pos_x    = longint'(POS_HALF);
        pos_y    = longint'(POS_HALF);
        lvl_pan  = longint'(CENTER) <<< FRAC;
        lvl_tilt = longint'(CENTER) <<< FRAC;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            in_idle_on  = !(p == 3 || p == 6);
            out_idle_on = !(p == 3 || p == 7);
            case (p)
                0: begin
                    // deadband edge: exactly on the band holds, one past it moves
                    push_frame(16'd36045, 16'd29491, 1'b1);
                    push_frame(16'd0, 16'd0, 1'b0);
                    push_frame(16'd36046, 16'd29490, 1'b1);
                    push_frame(16'hFFFF, 16'h0000, 1'b0);
                    push_frame(16'hFFFF, 16'hFFFF, 1'b1);
                    push_frame(16'h0000, 16'h0000, 1'b1);
                    push_frame(16'hFFFF, 16'h0000, 1'b1);
                    push_frame(16'h0000, 16'hFFFF, 1'b1);
                    repeat (4) push_frame(POS_HALF, POS_HALF, 1'b1);
                    repeat (3) push_frame(16'($urandom), 16'($urandom), 1'b0);
                    repeat (5) push_frame(16'h0000, 16'hFFFF, 1'b1);
                    push_frame(16'hFFFF, 16'hFFFF, 1'b0);
                end
                1: begin
                    set_all(16'($urandom_range(0, 4000)), 16'($urandom),
                            16'($urandom), 16'($urandom),
                            12'($urandom_range(0, 1000)), 12'($urandom_range(2000, 4095)),
                            12'($urandom_range(0, 1000)), 12'($urandom_range(2000, 4095)));
                    queue_frames(PHASE_LEN);
                end
                2: begin
                    // zero deadband, full gains, full pan range, swapped tilt range
                    set_all(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            12'h000, 12'hFFF, 12'hFFF, 12'h000);
                    queue_frames(PHASE_LEN);
                end
                3: begin
                    // widest deadband, zero gains, empty ranges
                    set_all(16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                            12'hFFF, 12'hFFF, 12'h000, 12'h000);
                    queue_frames(PHASE_LEN);
                end
                default: begin
                    set_all(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 4000)),
                            16'($urandom), 16'($urandom), 16'($urandom),
                            12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
                    queue_frames(PHASE_LEN);
                end
            endcase
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
